@@ src/trial_division_prime_test_defines.svh @@
// Assertion macros used by the RTL of the primality tester.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define TDPT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TDPT_ASSERT_IMPL(label, ante, cons, msg)
`define TDPT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/tdpt_pkg.sv @@
// Types shared by the trial-division primality tester.
package tdpt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

endpackage

@@ src/trial_division_prime_test.sv @@
// Primality tester: trial division by odd divisors through one shared restoring divider.
//
// One candidate is taken per input beat and one result beat comes back for it. The block
// works on one candidate at a time and takes no new beat until the result has been taken.
// Zero, one, two, three and even numbers are settled in the cycle after the input beat.
// Every other candidate c is divided by 3, 5, 7 and each later odd number with a bit-serial
// restoring divider that works through all dividend bits for each divisor and then judges
// its quotient and remainder; the search stops at the first divisor that divides c or once
// the divisor exceeds the quotient. A prime thus tries every odd divisor up to its square
// root, while composites stop early.
`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Bits from low: candidate, zero fill.
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // Bits from low: tested_value, is_prime, zero fill.
    output logic [((VALUE_WIDTH + 8) / 8) * 8 - 1:0] m_tdata
);

    localparam int W      = VALUE_WIDTH;
    localparam int OUT_W  = ((VALUE_WIDTH + 8) / 8) * 8;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);

    tdpt_pkg::state_t state_reg, state_next;

    logic [W-1:0]     c_reg, c_next;       // candidate, kept for the result
    logic [W-1:0]     d_reg, d_next;       // current trial divisor
    logic [W-1:0]     quo_reg, quo_next;   // dividend shifting out, quotient shifting in
    logic [W-1:0]     rem_reg, rem_next;   // partial remainder, always below d_reg
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             prime_reg, prime_next;

    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             take;
    logic [W-1:0]     cand;

    assign cand  = s_tdata[W-1:0];
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign take  = !diff[W];

    assign s_tready = (state_reg == tdpt_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == tdpt_pkg::ST_OUT);
    assign m_tdata  = OUT_W'({prime_reg, c_reg});

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        prime_next = prime_reg;
        unique case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    c_next   = cand;
                    d_next   = W'(3);
                    quo_next = cand;
                    rem_next = '0;
                    cnt_next = CNT_W'(W - 1);
                    if (cand[W-1:2] == '0)
                    begin
                        // Two and three are prime, zero and one are not.
                        prime_next = cand[1];
                        state_next = tdpt_pkg::ST_OUT;
                    end
                    else if (!cand[0])
                    begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = tdpt_pkg::ST_DIV;
                    end
                end
            end
            tdpt_pkg::ST_DIV:
            begin
                rem_next = take ? diff[W-1:0] : trial[W-1:0];
                quo_next = {quo_reg[W-2:0], take};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = tdpt_pkg::ST_DECIDE;
                end
            end
            tdpt_pkg::ST_DECIDE:
            begin
                if (d_reg > quo_reg)
                begin
                    // Divisor passed the square root with no hit.
                    prime_next = 1'b1;
                    state_next = tdpt_pkg::ST_OUT;
                end
                else if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    state_next = tdpt_pkg::ST_OUT;
                end
                else
                begin
                    d_next     = d_reg + W'(2);
                    quo_next   = c_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdpt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        d_reg     <= d_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        prime_reg <= prime_next;
    end

    `TDPT_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(state_reg), "state register is not one-hot")
    `TDPT_ASSERT_IMPL(a_ready_excl, s_tready, !m_tvalid, "ready for input while result pending")
    `TDPT_ASSERT_IMPL(a_rem_below_div, state_reg == tdpt_pkg::ST_DIV, rem_reg < d_reg,
                      "partial remainder not below divisor")
    `TDPT_ASSERT_IMPL(a_div_odd, state_reg == tdpt_pkg::ST_DIV, d_reg[0] && d_reg >= W'(3),
                      "trial divisor not odd or below three")
    `TDPT_ASSERT_NEXT(a_small_not_prime, s_tvalid && s_tready && s_tdata[W-1:1] == '0,
                      m_tvalid && !m_tdata[W], "zero or one not reported as composite")

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the trial-division primality tester.
module testbench;

    localparam int VALUE_WIDTH = 31;
    localparam int IN_BITS = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS = ((VALUE_WIDTH + 8) / 8) * 8;
    localparam int CLK_PERIOD = 12;
    localparam int RANDOM_ITEMS = 78;
    localparam int PROBE_COUNT = 22;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    // The largest probe prime tries every odd divisor up to its square root, so the limit is wide.
    localparam longint LIMIT_CYCLES = 10_000_000;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct {
        value_t value;
        logic   prime;
    } verdict_t;

    typedef struct {
        value_t value;
        bit     typed;
        bit     prime;
    } probe_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    verdict_t verdicts_due[$];
    int       error_count = 0;
    int       verdicts_seen = 0;
    int       primes_seen = 0;
    int       candidates_sent = 0;
    int       sender_idle_pct = 0;
    int       receiver_idle_pct = 0;
    int       rx_hold_left = 0;

    // Values that are not obvious are checked against the predictor only.
    probe_row_t probe_rows [0:PROBE_COUNT-1] = '{
        '{31'd0,          1'b1, 1'b0},
        '{31'd1,          1'b1, 1'b0},
        '{31'd2,          1'b1, 1'b1},
        '{31'd3,          1'b1, 1'b1},
        '{31'd4,          1'b1, 1'b0},
        '{31'd5,          1'b0, 1'b0},
        '{31'd6,          1'b1, 1'b0},
        '{31'd9,          1'b0, 1'b0},
        '{31'd15,         1'b0, 1'b0},
        '{31'd25,         1'b0, 1'b0},
        '{31'd49,         1'b0, 1'b0},
        '{31'd121,        1'b0, 1'b0},
        '{31'd169,        1'b0, 1'b0},
        '{31'd65535,      1'b0, 1'b0},
        '{31'd65537,      1'b0, 1'b0},
        '{31'd1018081,    1'b0, 1'b0},
        '{31'd1073741824, 1'b1, 1'b0},
        '{31'd715827882,  1'b1, 1'b0},
        '{31'd1431655765, 1'b0, 1'b0},
        '{31'd2147483645, 1'b0, 1'b0},
        '{31'd2147483646, 1'b1, 1'b0},
        '{31'd2147483647, 1'b0, 1'b0}
    };

    trial_division_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Odd divisors only, stopping once the divisor passes the square root.
    function automatic logic prime_by_trial(input value_t candidate);
        longint unsigned n;
        longint unsigned d;
        n = candidate;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if ((n & 1) == 0)
            return 1'b0;
        for (d = 3; d <= n / d; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly small values; the largest ones are even or carry a small factor so the search ends quickly.
    function automatic value_t random_candidate();
        int unsigned    mode;
        int unsigned    bits;
        int unsigned    factor;
        longint unsigned n;
        mode = $urandom_range(99);
        if (mode < 60)
        begin
            bits = $urandom_range(16, 1);
            n = $urandom & ((64'd1 << bits) - 1);
        end
        else if (mode < 72)
        begin
            n = $urandom_range(262143, 65536);
        end
        else if (mode < 84)
        begin
            n = $urandom & 32'h7FFF_FFFE;
        end
        else
        begin
            case ($urandom_range(4))
                0: factor = 3;
                1: factor = 5;
                2: factor = 7;
                3: factor = 11;
                default: factor = 13;
            endcase
            n = longint'($urandom_range(32'h7FFF_FFFF / factor, 1)) * factor;
        end
        return value_t'(n);
    endfunction

    task automatic report_mismatch(input string what, input value_t got, input value_t want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Offers one candidate and waits for its beat; tvalid stays high for a back-to-back item.
    task automatic send_candidate(input value_t value, input bit typed, input bit prime);
        verdict_t due;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'(value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due.value = value;
        due.prime = typed ? prime : prime_by_trial(value);
        verdicts_due.push_back(due);
        candidates_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_candidate(random_candidate(), 1'b0, 1'b0);
    endtask

    // Result side: checks every accepted beat, then picks tready for the next edge.
    initial
    begin
        verdict_t due;
        value_t   got_value;
        logic     got_prime;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got_value = m_tdata[VALUE_WIDTH-1:0];
                got_prime = m_tdata[VALUE_WIDTH];
                verdicts_seen++;
                if (got_prime)
                    primes_seen++;
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("unexpected result beat", got_value, '0);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (got_value !== due.value)
                        report_mismatch("tested_value", got_value, due.value);
                    if (got_prime !== due.prime)
                        report_mismatch($sformatf("is_prime of %0d", due.value),
                                        value_t'(got_prime), value_t'(due.prime));
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 6;
        receiver_idle_pct = 85;
        for (int i = 0; i < PROBE_COUNT; i++)
            send_candidate(probe_rows[i].value, probe_rows[i].typed, probe_rows[i].prime);
        send_random(30);

        sender_idle_pct   = 85;
        receiver_idle_pct = 6;
        send_random(30);

        // The receiver stalls for a long stretch so the block holds a result and refuses input.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        rx_hold_left      = HOLD_OFF_CYCLES;
        send_random(RANDOM_ITEMS - 60);

        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d candidates (%0d directed, rest random) under three idling mixes.",
                 candidates_sent, PROBE_COUNT);
        $display("Checked %0d result beats, %0d of them prime.", verdicts_seen, primes_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
